// File: rtl/bdlp_pkg.sv
// Shared constants and types for the button debounce / long press event block.
// No dependencies; imported by bdlp_tick_sub and button_debounce_long_press_events.
package bdlp_pkg;

    localparam int TICK_W   = 32;
    localparam int KEY_W    = 3;
    localparam int TYPE_W   = 3;
    localparam int SEQ_W    = 32;
    localparam int AGREE_W  = 4;
    localparam int BTN_FIELD = 5;   // buttons carried by the fixed-width fields
    localparam int MAP_W    = BTN_FIELD * KEY_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MAP   = 3'd5;

    localparam logic [BTN_FIELD-1:0] RST_ACTIVE_LOW = 5'd31;
    localparam logic [AGREE_W-1:0]   RST_DEBOUNCE   = 4'd2;
    localparam logic [TICK_W-1:0]    RST_HOLD       = 32'd500;
    localparam logic [TICK_W-1:0]    RST_REPEAT     = 32'd200;
    localparam logic [MAP_W-1:0]     RST_TAP_MAP    = 15'd17608;
    localparam logic [MAP_W-1:0]     RST_HOLD_MAP   = 15'd17736;

    localparam logic [KEY_W-1:0] KEY_BACK = 3'd5;

    localparam logic [TYPE_W-1:0] EV_PRESS   = 3'd0;
    localparam logic [TYPE_W-1:0] EV_RELEASE = 3'd1;
    localparam logic [TYPE_W-1:0] EV_SHORT   = 3'd2;
    localparam logic [TYPE_W-1:0] EV_LONG    = 3'd3;
    localparam logic [TYPE_W-1:0] EV_REPEAT  = 3'd4;

    // Event group to emit for one button
    typedef enum logic [1:0] {
        ACT_TAP  = 2'd0,    // press, short, release
        ACT_LONG = 2'd1,    // press, long (short for back)
        ACT_REL  = 2'd2,    // release after long
        ACT_REP  = 2'd3     // repeat
    } t_act;

    typedef struct packed {
        logic              en;
        logic [TICK_W-1:0] a;
        logic [TICK_W-1:0] b;
    } t_sub_req;

    typedef struct packed {
        logic [TICK_W-1:0] diff;
        logic              ge;
    } t_sub_rsp;

endpackage

// File: rtl/bdlp_tick_sub.sv
// Shared 32-bit tick subtractor: registers a - b (mod 2^32) and a >= b.
// Depends on bdlp_pkg.
module bdlp_tick_sub (
    input  logic               i_clk,
    input  bdlp_pkg::t_sub_req i_req,
    output bdlp_pkg::t_sub_rsp o_rsp
);
    import bdlp_pkg::*;

    logic [TICK_W:0]   sum;
    logic [TICK_W-1:0] r_diff;
    logic              r_ge;

    assign sum = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_diff <= sum[TICK_W-1:0];
            r_ge   <= ~sum[TICK_W];   // no borrow
        end
    end

    assign o_rsp.diff = r_diff;
    assign o_rsp.ge   = r_ge;

endmodule

// File: rtl/button_debounce_long_press_events.sv
// Top level: button debouncer with short, long and repeat key events.
// Depends on bdlp_pkg and bdlp_tick_sub.
//
//  channel   dir  handshake                  payload
//  s (poll)  in   i_s_tvalid / o_s_tready    i_s_tdata: now_tick, raw_levels
//  m (event) out  o_m_tvalid / i_m_tready    o_m_tdata: key, type, sequence; o_m_tlast
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One poll is worked button by button by a small sequencer: a debounce step per
// button, subtract, compare and decide steps where a held button needs its tick
// checks on the shared subtractor, an emit step per event, plus the accept and a
// final flush step. Events wait in a pending stage so the last one can carry tlast;
// a stalled output holds the sequencer. Reset is synchronous; no item is taken
// until the poll in hand has emitted all of its events.
module button_debounce_long_press_events #(
    parameter int BUTTONS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bdlp_pkg::S_TDATA_W-1:0] i_s_tdata,  // [31:0] now_tick, [36:32] raw_levels
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bdlp_pkg::M_TDATA_W-1:0] o_m_tdata,  // [2:0] key, [5:3] type, [37:6] sequence
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import bdlp_pkg::*;

    localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTONS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEB    = 3'd1;
    localparam logic [2:0] S_DIFF   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    // configuration
    logic [BTN_FIELD-1:0] r_cfg_low;
    logic [AGREE_W-1:0]   r_cfg_deb;
    logic [TICK_W-1:0]    r_cfg_hold;
    logic [TICK_W-1:0]    r_cfg_rep;
    logic [MAP_W-1:0]     r_cfg_tap;
    logic [MAP_W-1:0]     r_cfg_hmap;

    // sequencer
    logic [2:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [TICK_W-1:0]    r_now;
    logic [BTN_FIELD-1:0] r_levels;
    t_act                 r_act, n_act;
    logic [1:0]           r_step, n_step;
    logic [KEY_W-1:0]     r_ev_key, n_ev_key;
    logic [SEQ_W-1:0]     r_ev_seq, n_ev_seq;
    logic [SEQ_W-1:0]     r_counter, n_counter;

    // per-button state
    logic                 r_seen     [BUTTONS];
    logic                 r_stable   [BUTTONS];
    logic [AGREE_W-1:0]   r_agree    [BUTTONS];
    logic                 r_reported [BUTTONS];
    logic [TICK_W-1:0]    r_hold_start [BUTTONS];
    logic [TICK_W-1:0]    r_rep_mark   [BUTTONS];

    // output register and pending stage
    logic                 r_out_valid, n_out_valid;
    logic [KEY_W-1:0]     r_out_key, n_out_key;
    logic [TYPE_W-1:0]    r_out_type, n_out_type;
    logic [SEQ_W-1:0]     r_out_seq, n_out_seq;
    logic                 r_out_last, n_out_last;
    logic                 r_pend_valid, n_pend_valid;
    logic [KEY_W-1:0]     r_pend_key, n_pend_key;
    logic [TYPE_W-1:0]    r_pend_type, n_pend_type;
    logic [SEQ_W-1:0]     r_pend_seq, n_pend_seq;

    // per-button views of the fixed-width fields
    logic                 lvl_b  [BUTTONS];
    logic                 low_b  [BUTTONS];
    logic [KEY_W-1:0]     tkey_b [BUTTONS];
    logic [KEY_W-1:0]     hkey_b [BUTTONS];

    logic                 cur_raw, cur_rep, seen_n, settled, slot_free, ev_final, upd;
    logic [AGREE_W-1:0]   agree_n;
    logic [KEY_W-1:0]     cur_hkey;
    logic [TYPE_W-1:0]    ev_type;
    logic                 n_seen, n_stable, n_reported;
    logic                 hs_we, rm_we;
    t_sub_req             sub_req;
    t_sub_rsp             sub_rsp;

    bdlp_tick_sub u_sub (
        .i_clk (i_clk),
        .i_req (sub_req),
        .o_rsp (sub_rsp)
    );

    always_comb begin
        for (int b = 0; b < BUTTONS; b++) begin
            lvl_b[b]  = 1'b0;
            low_b[b]  = 1'b0;
            tkey_b[b] = '0;
            hkey_b[b] = '0;
            if (b < BTN_FIELD) begin
                lvl_b[b]  = r_levels[b];
                low_b[b]  = r_cfg_low[b];
                tkey_b[b] = r_cfg_tap[KEY_W*b +: KEY_W];
                hkey_b[b] = r_cfg_hmap[KEY_W*b +: KEY_W];
            end
        end
    end

    assign cur_raw  = lvl_b[r_idx] ^ low_b[r_idx];
    assign cur_rep  = r_reported[r_idx];
    assign cur_hkey = hkey_b[r_idx];

    always_comb begin
        if (cur_raw == r_seen[r_idx]) begin
            seen_n  = r_seen[r_idx];
            agree_n = (r_agree[r_idx] < r_cfg_deb) ? r_agree[r_idx] + 1'b1 : r_agree[r_idx];
        end else begin
            seen_n  = cur_raw;
            agree_n = AGREE_W'(1);
        end
    end
    assign settled = (agree_n >= r_cfg_deb);

    always_comb begin
        sub_req.en = (r_state == S_DIFF) || (r_state == S_CMP);
        sub_req.a  = (r_state == S_DIFF) ? r_now : sub_rsp.diff;
        if (r_state == S_DIFF) begin
            sub_req.b = cur_rep ? r_rep_mark[r_idx] : r_hold_start[r_idx];
        end else begin
            sub_req.b = cur_rep ? r_cfg_rep : r_cfg_hold;
        end
    end

    always_comb begin
        ev_type  = EV_RELEASE;
        ev_final = 1'b1;
        case (r_act)
            ACT_TAP: begin
                ev_final = (r_step == 2'd2);
                if (r_step == 2'd0)      ev_type = EV_PRESS;
                else if (r_step == 2'd1) ev_type = EV_SHORT;
                else                     ev_type = EV_RELEASE;
            end
            ACT_LONG: begin
                ev_final = (r_step == 2'd1);
                if (r_step == 2'd0)            ev_type = EV_PRESS;
                else if (r_ev_key == KEY_BACK) ev_type = EV_SHORT;
                else                           ev_type = EV_LONG;
            end
            ACT_REL: ev_type = EV_RELEASE;
            default: ev_type = EV_REPEAT;
        endcase
    end

    assign slot_free = ~r_out_valid | i_m_tready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_act        = r_act;
        n_step       = r_step;
        n_ev_key     = r_ev_key;
        n_ev_seq     = r_ev_seq;
        n_counter    = r_counter;
        n_seen       = r_seen[r_idx];
        n_stable     = r_stable[r_idx];
        n_reported   = r_reported[r_idx];
        upd          = 1'b0;
        hs_we        = 1'b0;
        rm_we        = 1'b0;
        n_out_valid  = r_out_valid & ~i_m_tready;
        n_out_key    = r_out_key;
        n_out_type   = r_out_type;
        n_out_seq    = r_out_seq;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_key   = r_pend_key;
        n_pend_type  = r_pend_type;
        n_pend_seq   = r_pend_seq;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DEB;
                    n_idx   = '0;
                end
            end
            S_DEB: begin
                upd     = 1'b1;
                n_seen  = seen_n;
                n_state = (r_idx == IDX_LAST) ? S_FLUSH : S_DEB;
                n_idx   = r_idx + 1'b1;
                if (settled) begin
                    if (r_stable[r_idx] == seen_n) begin
                        if (r_stable[r_idx]) begin
                            n_state = S_DIFF;
                            n_idx   = r_idx;
                        end
                    end else begin
                        n_stable = seen_n;
                        if (seen_n) begin
                            hs_we      = 1'b1;
                            n_reported = 1'b0;
                        end else begin
                            n_state = S_EMIT;
                            n_idx   = r_idx;
                            n_step  = 2'd0;
                            if (cur_rep) begin
                                n_act    = ACT_REL;
                                n_ev_key = cur_hkey;
                                n_ev_seq = r_counter;
                            end else begin
                                n_act     = ACT_TAP;
                                n_ev_key  = tkey_b[r_idx];
                                n_counter = r_counter + 1'b1;
                                n_ev_seq  = r_counter + 1'b1;
                            end
                        end
                    end
                end
            end
            S_DIFF: n_state = S_CMP;
            S_CMP:  n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = (r_idx == IDX_LAST) ? S_FLUSH : S_DEB;
                n_idx   = r_idx + 1'b1;
                if (sub_rsp.ge) begin
                    upd   = 1'b1;
                    rm_we = 1'b1;
                    n_step   = 2'd0;
                    n_ev_key = cur_hkey;
                    if (!cur_rep) begin
                        n_reported = 1'b1;
                        n_counter  = r_counter + 1'b1;
                        n_ev_seq   = r_counter + 1'b1;
                        n_act      = ACT_LONG;
                        n_state    = S_EMIT;
                        n_idx      = r_idx;
                    end else if (cur_hkey != KEY_BACK) begin
                        n_ev_seq = r_counter;
                        n_act    = ACT_REP;
                        n_state  = S_EMIT;
                        n_idx    = r_idx;
                    end
                end
            end
            S_EMIT: begin
                if (!r_pend_valid || slot_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_key   = r_pend_key;
                        n_out_type  = r_pend_type;
                        n_out_seq   = r_pend_seq;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_key   = r_ev_key;
                    n_pend_type  = ev_type;
                    n_pend_seq   = r_ev_seq;
                    if (ev_final) begin
                        n_state = (r_idx == IDX_LAST) ? S_FLUSH : S_DEB;
                        n_idx   = r_idx + 1'b1;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_pend_key;
                    n_out_type   = r_pend_type;
                    n_out_seq    = r_pend_seq;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_counter    <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            for (int b = 0; b < BUTTONS; b++) begin
                r_seen[b]     <= 1'b0;
                r_stable[b]   <= 1'b0;
                r_agree[b]    <= RST_DEBOUNCE;
                r_reported[b] <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_counter    <= n_counter;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            if (upd) begin
                r_seen[r_idx]     <= n_seen;
                r_stable[r_idx]   <= n_stable;
                r_reported[r_idx] <= n_reported;
                if (r_state == S_DEB) r_agree[r_idx] <= agree_n;
            end
        end
    end

    // payload: tick marks are written before they are ever read
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_now    <= i_s_tdata[TICK_W-1:0];
            r_levels <= i_s_tdata[TICK_W +: BTN_FIELD];
        end
        if (hs_we) r_hold_start[r_idx] <= r_now;
        if (rm_we) r_rep_mark[r_idx]   <= r_now;
        r_act       <= n_act;
        r_step      <= n_step;
        r_ev_key    <= n_ev_key;
        r_ev_seq    <= n_ev_seq;
        r_out_key   <= n_out_key;
        r_out_type  <= n_out_type;
        r_out_seq   <= n_out_seq;
        r_out_last  <= n_out_last;
        r_pend_key  <= n_pend_key;
        r_pend_type <= n_pend_type;
        r_pend_seq  <= n_pend_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low  <= RST_ACTIVE_LOW;
            r_cfg_deb  <= RST_DEBOUNCE;
            r_cfg_hold <= RST_HOLD;
            r_cfg_rep  <= RST_REPEAT;
            r_cfg_tap  <= RST_TAP_MAP;
            r_cfg_hmap <= RST_HOLD_MAP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LOW: r_cfg_low  <= i_cfg_data[BTN_FIELD-1:0];
                CFG_DEBOUNCE:   r_cfg_deb  <= i_cfg_data[AGREE_W-1:0];
                CFG_HOLD:       r_cfg_hold <= i_cfg_data[TICK_W-1:0];
                CFG_REPEAT:     r_cfg_rep  <= i_cfg_data[TICK_W-1:0];
                CFG_TAP_MAP:    r_cfg_tap  <= i_cfg_data[MAP_W-1:0];
                CFG_HOLD_MAP:   r_cfg_hmap <= i_cfg_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(M_TDATA_W - SEQ_W - TYPE_W - KEY_W){1'b0}},
                          r_out_seq, r_out_type, r_out_key};
    assign o_m_tlast   = r_out_last;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_pend_valid)
        else $error("pending event left over when ready for a new item");

    a_decide_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> ($past(r_state) == S_CMP))
        else $error("tick compare used without a preceding subtract");

    a_flush_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) && !r_pend_valid |=> o_s_tready)
        else $error("poll did not finish after final flush");
`endif

endmodule
